### rtl/sers_pkg.sv
// Shared types, codes and constants of the sorted equal-range search unit.
`timescale 1ns / 1ps

package sers_pkg;

    // Widths fixed by the item fields
    localparam int unsigned LEN_W  = 11;   // used length register
    localparam int unsigned EIDX_W = 10;   // write position field
    localparam int unsigned DATA_W = 32;   // entry value / key
    localparam int unsigned POS_W  = 12;   // signed range ends and hit position
    localparam int unsigned Q_W    = 11;   // quarter point (never negative)
    localparam int unsigned STEP_W = 3;    // microprogram step counter

    localparam logic signed [POS_W-1:0] HIT_NONE = -12'sd1;
    localparam logic signed [LEN_W-1:0] OUT_NONE = -11'sd1;

    // Request type codes
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef logic [STEP_W-1:0] t_step;

    // Microprogram step addresses
    localparam t_step ST_IDLE     = 3'd0;
    localparam t_step ST_CHECK    = 3'd1;
    localparam t_step ST_RD1      = 3'd2;
    localparam t_step ST_RD2      = 3'd3;
    localparam t_step ST_RD3      = 3'd4;
    localparam t_step ST_NARROW   = 3'd5;
    localparam t_step ST_PASS_END = 3'd6;
    localparam t_step ST_RESULT   = 3'd7;

    // Datapath operation of one step
    typedef enum logic [2:0] {
        DP_NOP      = 3'd0,
        DP_QUARTERS = 3'd1,
        DP_NARROW   = 3'd2,
        DP_PASS_END = 3'd3,
        DP_RESULT   = 3'd4
    } t_dp_op;

    // Table read address select
    typedef enum logic [1:0] {
        RD_NONE = 2'd0,
        RD_Q1   = 2'd1,
        RD_Q2   = 2'd2,
        RD_Q3   = 2'd3
    } t_rd_sel;

    // Jump condition
    typedef enum logic [2:0] {
        C_NEVER       = 3'd0,
        C_ALWAYS      = 3'd1,
        C_NO_SEARCH   = 3'd2,
        C_RANGE_EMPTY = 3'd3,
        C_UPPER_START = 3'd4,
        C_OUT_BUSY    = 3'd5
    } t_cond;

    // One control word of the microprogram
    typedef struct packed {
        logic    accept;
        t_dp_op  dp_op;
        t_rd_sel rd_sel;
        logic    cap_v1;
        logic    cap_v2;
        t_cond   cond;
        t_step   jmp;
        t_step   nxt;
    } t_uword;

    // Datapath flags tested by jump conditions
    typedef struct packed {
        logic search_start;
        logic range_empty;
        logic upper_start;
        logic out_busy;
    } t_dp_status;

endpackage

### rtl/sorted_equal_range_search_unit.sv
// Top level of the sorted equal-range search unit.
// Usage: the block keeps a table of signed 32-bit entries in ascending order.
// Input channel (i_in_valid / o_in_ready): a transfer with i_req_type 0 writes
// i_data_value at i_entry_index (positions at or past the depth are dropped)
// and gives no result; a transfer with i_req_type 1 searches for the key
// i_data_value among the first used_length entries (i_cfg_we / i_cfg_wdata,
// clamped to the depth). Output channel (o_out_valid / i_out_ready) returns
// the lowest and highest position of the key and o_found, or -1, -1 and 0.
// Steps: a write is taken in the idle step. A search runs the idle step that
// takes it, one or two passes and the result step; a pass runs quarter-point
// rounds (range check, three probe reads, narrowing) until its range is empty,
// then its pass-end step. A miss needs only the lower pass; a hit in the upper
// pass drops only a quarter of the range, so a hit costs most when every entry
// holds the key. The single read port of the table memory sets the round
// length: three probe reads per round, one per cycle, then the narrowing step.
// One search runs at a time; writes are taken whenever the unit is idle.
// Reset (synchronous, active low) clears the used length, the sequencer and
// the output valid; table contents are undefined until written.
// A stalled receiver holds the result; the unit still takes writes and a new
// search, which waits in its result step until the output register is free.
`timescale 1ns / 1ps

module sorted_equal_range_search_unit #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [sers_pkg::LEN_W-1:0]           i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_req_type,
    input  logic [sers_pkg::EIDX_W-1:0]          i_entry_index,
    input  logic signed [sers_pkg::DATA_W-1:0]   i_data_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [sers_pkg::LEN_W-1:0]    o_first_index,
    output logic signed [sers_pkg::LEN_W-1:0]    o_last_index,
    output logic                                 o_found
);
    import sers_pkg::*;

    t_uword     uword;
    t_dp_status status;

    // Sequencer with the control store
    sers_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_uword  (uword)
    );

    // Datapath with the table memory
    sers_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_uword       (uword),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .i_req_type    (i_req_type),
        .i_entry_index (i_entry_index),
        .i_data_value  (i_data_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_first_index (o_first_index),
        .o_last_index  (o_last_index),
        .o_found       (o_found)
    );

    // Take input only in the idle step
    assign o_in_ready = uword.accept;

endmodule

### rtl/sers_seq.sv
// Microprogram sequencer: step counter, control store and jump logic.
`timescale 1ns / 1ps

module sers_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sers_pkg::t_dp_status  i_status,
    output sers_pkg::t_uword      o_uword
);
    import sers_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword uword;
    logic   take_jmp;

    // Control store, one word per step
    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        w = '{accept: 1'b0, dp_op: DP_NOP, rd_sel: RD_NONE, cap_v1: 1'b0,
              cap_v2: 1'b0, cond: C_NEVER, jmp: ST_IDLE, nxt: ST_IDLE};
        case (step)
            ST_IDLE: begin
                w.accept = 1'b1;
                w.cond   = C_NO_SEARCH;
                w.jmp    = ST_IDLE;
                w.nxt    = ST_CHECK;
            end
            ST_CHECK: begin
                w.dp_op = DP_QUARTERS;
                w.cond  = C_RANGE_EMPTY;
                w.jmp   = ST_PASS_END;
                w.nxt   = ST_RD1;
            end
            ST_RD1: begin
                w.rd_sel = RD_Q1;
                w.nxt    = ST_RD2;
            end
            ST_RD2: begin
                w.rd_sel = RD_Q2;
                w.cap_v1 = 1'b1;
                w.nxt    = ST_RD3;
            end
            ST_RD3: begin
                w.rd_sel = RD_Q3;
                w.cap_v2 = 1'b1;
                w.nxt    = ST_NARROW;
            end
            ST_NARROW: begin
                w.dp_op = DP_NARROW;
                w.cond  = C_ALWAYS;
                w.jmp   = ST_CHECK;
            end
            ST_PASS_END: begin
                w.dp_op = DP_PASS_END;
                w.cond  = C_UPPER_START;
                w.jmp   = ST_CHECK;
                w.nxt   = ST_RESULT;
            end
            ST_RESULT: begin
                w.dp_op = DP_RESULT;
                w.cond  = C_OUT_BUSY;
                w.jmp   = ST_RESULT;
                w.nxt   = ST_IDLE;
            end
            default: begin
                w.nxt = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    assign uword   = ucode_rom(r_step);
    assign o_uword = uword;

    // Evaluate the jump condition of the current word
    always_comb begin
        case (uword.cond)
            C_NEVER:       take_jmp = 1'b0;
            C_ALWAYS:      take_jmp = 1'b1;
            C_NO_SEARCH:   take_jmp = !i_status.search_start;
            C_RANGE_EMPTY: take_jmp = i_status.range_empty;
            C_UPPER_START: take_jmp = i_status.upper_start;
            C_OUT_BUSY:    take_jmp = i_status.out_busy;
            default:       take_jmp = 1'b0;
        endcase
        n_step = take_jmp ? uword.jmp : uword.nxt;
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // A search transfer always starts the range check next
    a_search_enters_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_IDLE && i_status.search_start) |=> (r_step == ST_CHECK))
        else $error("search did not enter the range check");

endmodule

### rtl/sers_dp.sv
// Datapath: table memory, range registers, quarter points, probes and result register.
`timescale 1ns / 1ps

module sers_dp #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sers_pkg::t_uword                     i_uword,
    output sers_pkg::t_dp_status                 o_status,
    input  logic                                 i_cfg_we,
    input  logic [sers_pkg::LEN_W-1:0]           i_cfg_wdata,
    input  logic                                 i_in_valid,
    input  logic                                 i_req_type,
    input  logic [sers_pkg::EIDX_W-1:0]          i_entry_index,
    input  logic signed [sers_pkg::DATA_W-1:0]   i_data_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [sers_pkg::LEN_W-1:0]    o_first_index,
    output logic signed [sers_pkg::LEN_W-1:0]    o_last_index,
    output logic                                 o_found
);
    import sers_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);

    logic [DATA_W-1:0] mem [TABLE_DEPTH];

    logic [LEN_W-1:0]         r_used_length;
    logic [LEN_W-1:0]         r_len;
    logic signed [DATA_W-1:0] r_key;
    logic signed [POS_W-1:0]  r_lo;
    logic signed [POS_W-1:0]  r_hi;
    logic signed [POS_W-1:0]  r_hit;
    logic signed [POS_W-1:0]  r_first;
    logic                     r_upper;
    logic [Q_W-1:0]           r_q1;
    logic [Q_W-1:0]           r_q2;
    logic [Q_W-1:0]           r_q3;
    logic [DATA_W-1:0]        r_rdata;
    logic [DATA_W-1:0]        r_v1;
    logic [DATA_W-1:0]        r_v2;
    logic                     r_out_valid;

    logic                     in_xfer;
    logic                     wr_en;
    logic                     search_start;
    logic [31:0]              wr_ext;
    logic [AW-1:0]            wr_addr;
    logic [Q_W-1:0]           rd_q;
    logic [31:0]              rd_ext;
    logic [AW-1:0]            rd_addr;
    logic [LEN_W-1:0]         len_sat;
    logic [Q_W-1:0]           lo_u;
    logic [Q_W-1:0]           hi_u;
    logic [Q_W+1:0]           sum1;
    logic [Q_W:0]             sum2;
    logic [Q_W+1:0]           sum3;
    logic                     eq1;
    logic                     eq2;
    logic                     eq3;
    logic [Q_W-1:0]           q_hit;
    logic signed [POS_W-1:0]  len_m1;
    logic                     out_busy;

    // Input transfer decode
    assign in_xfer      = i_uword.accept && i_in_valid;
    assign wr_en        = in_xfer && (i_req_type == REQ_WRITE) &&
                          (32'(i_entry_index) < TABLE_DEPTH);
    assign search_start = in_xfer && (i_req_type == REQ_SEARCH);
    assign wr_ext       = 32'(i_entry_index);
    assign wr_addr      = wr_ext[AW-1:0];

    // Clamp the used length to the table depth
    assign len_sat = (32'(r_used_length) > TABLE_DEPTH) ? LEN_W'(TABLE_DEPTH)
                                                        : r_used_length;
    assign len_m1  = $signed({1'b0, r_len}) - POS_W'(1);

    // Select the probe address
    always_comb begin
        case (i_uword.rd_sel)
            RD_Q1:   rd_q = r_q1;
            RD_Q2:   rd_q = r_q2;
            RD_Q3:   rd_q = r_q3;
            default: rd_q = r_q1;
        endcase
    end
    assign rd_ext  = 32'(rd_q);
    assign rd_addr = rd_ext[AW-1:0];

    // Table memory: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_data_value;
        end
        if (i_uword.rd_sel != RD_NONE) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Quarter points of a non-empty range, by shift and add
    assign lo_u = r_lo[Q_W-1:0];
    assign hi_u = r_hi[Q_W-1:0];
    assign sum1 = {1'b0, lo_u, 1'b0} + {2'b00, lo_u} + {2'b00, hi_u};
    assign sum2 = {1'b0, lo_u} + {1'b0, hi_u};
    assign sum3 = {1'b0, hi_u, 1'b0} + {2'b00, hi_u} + {2'b00, lo_u};

    // Probe compares; the third value is still in the read register
    assign eq1   = ($signed(r_v1) == r_key);
    assign eq2   = ($signed(r_v2) == r_key);
    assign eq3   = ($signed(r_rdata) == r_key);
    assign q_hit = eq1 ? r_q1 : (eq2 ? r_q2 : r_q3);

    assign out_busy = r_out_valid && !i_out_ready;

    // Status back to the sequencer
    assign o_status.search_start = search_start;
    assign o_status.range_empty  = (r_lo > r_hi);
    assign o_status.upper_start  = !r_upper && !r_hit[POS_W-1];
    assign o_status.out_busy     = out_busy;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_length <= '0;
        end else if (i_cfg_we) begin
            r_used_length <= i_cfg_wdata;
        end
    end

    // Capture the first two probe values
    always_ff @(posedge i_clk) begin
        if (i_uword.cap_v1) begin
            r_v1 <= r_rdata;
        end
        if (i_uword.cap_v2) begin
            r_v2 <= r_rdata;
        end
    end

    // Search registers: start, quarter points, narrowing, pass end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper <= 1'b0;
        end else begin
            if (search_start) begin
                r_key   <= i_data_value;
                r_len   <= len_sat;
                r_lo    <= '0;
                r_hi    <= $signed({1'b0, len_sat}) - POS_W'(1);
                r_hit   <= HIT_NONE;
                r_upper <= 1'b0;
            end
            case (i_uword.dp_op)
                DP_QUARTERS: begin
                    r_q1 <= sum1[Q_W+1:2];
                    r_q2 <= sum2[Q_W:1];
                    r_q3 <= sum3[Q_W+1:2];
                end
                DP_NARROW: begin
                    if (eq1 || eq2 || eq3) begin
                        r_hit <= $signed({1'b0, q_hit});
                        if (r_upper) begin
                            r_lo <= $signed({1'b0, q_hit}) + POS_W'(1);
                        end else begin
                            r_hi <= $signed({1'b0, q_hit}) - POS_W'(1);
                        end
                    end else if ($signed(r_v1) > r_key) begin
                        r_hi <= $signed({1'b0, r_q1}) - POS_W'(1);
                    end else if ($signed(r_v2) > r_key) begin
                        r_lo <= $signed({1'b0, r_q1}) + POS_W'(1);
                        r_hi <= $signed({1'b0, r_q2}) - POS_W'(1);
                    end else if ($signed(r_rdata) > r_key) begin
                        r_lo <= $signed({1'b0, r_q2}) + POS_W'(1);
                        r_hi <= $signed({1'b0, r_q3}) - POS_W'(1);
                    end else begin
                        r_lo <= $signed({1'b0, r_q3}) + POS_W'(1);
                    end
                end
                DP_PASS_END: begin
                    if (!r_upper) begin
                        r_first <= r_hit;
                        if (!r_hit[POS_W-1]) begin
                            r_upper <= 1'b1;
                            r_lo    <= r_hit;
                            r_hi    <= len_m1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result register: load when free, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_uword.dp_op == DP_RESULT && !out_busy) begin
            r_out_valid   <= 1'b1;
            o_first_index <= r_first[LEN_W-1:0];
            o_last_index  <= r_upper ? r_hit[LEN_W-1:0] : OUT_NONE;
            o_found       <= r_upper;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    // The upper pass only moves its hit upward from the first hit
    a_upper_hit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upper |-> (r_hit >= r_first && !r_first[POS_W-1]))
        else $error("upper pass hit below first hit");

    // The range end never passes the last used entry during a search
    a_hi_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_uword.accept |-> (r_hi < $signed({1'b0, r_len})))
        else $error("range end beyond used length");

    // A miss reports no position at all
    a_miss_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_found) |-> (o_first_index == OUT_NONE && o_last_index == OUT_NONE))
        else $error("miss with a position");

    // A hit reports real positions
    a_hit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_found) |-> (o_first_index != OUT_NONE && o_last_index != OUT_NONE))
        else $error("hit without a position");

endmodule
